### sv/sbht_pkg.sv
// Package for the sorted-bucket hash table: sizes, command and status codes.
package sbht_pkg;

  // Table geometry
  localparam int BUCKETS = 16;   // power of two: bucket is the low key bits
  localparam int SLOTS   = 8;

  localparam int KEY_W    = 31;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W   = $clog2(SLOTS + 1);
  localparam int ADDR_W   = BUCKET_W + SLOT_W;

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(SLOTS);

  // Command codes; the unused code runs as a search
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

endpackage

### sv/sbht_cmd_if.sv
// Command channel: one insert, search or remove item per handshake.
interface sbht_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [sbht_pkg::CMD_W-1:0]      command;
  logic [sbht_pkg::KEY_W-1:0]      key;

  modport source (output valid, command, key, input ready);
  modport sink   (input valid, command, key, output ready);
endinterface

### sv/sbht_rsp_if.sv
// Response channel: one status item per command.
interface sbht_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [sbht_pkg::STATUS_W-1:0]   status;
  logic [sbht_pkg::BUCKET_W-1:0]   bucket;
  logic [sbht_pkg::FILL_W-1:0]     bucket_fill;

  modport source (output valid, status, bucket, bucket_fill, input ready);
  modport sink   (input valid, status, bucket, bucket_fill, output ready);
endinterface

### sv/sbht_slot_ram.sv
// Key storage: one write port, one read port with registered read data.
module sbht_slot_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [sbht_pkg::ADDR_W-1:0]  waddr_i,
  input  logic [sbht_pkg::KEY_W-1:0]   wdata_i,
  input  logic                         re_i,
  input  logic [sbht_pkg::ADDR_W-1:0]  raddr_i,
  output logic [sbht_pkg::KEY_W-1:0]   rdata_o
);

  logic [sbht_pkg::KEY_W-1:0] mem_q [sbht_pkg::BUCKETS * sbht_pkg::SLOTS];
  logic [sbht_pkg::KEY_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sorted_bucket_hash_table.sv
// Top level of the sorted-bucket hash table.
//
// Each command item inserts, searches for or removes a key in bucket
// (key mod 16); a bucket keeps up to 8 keys in ascending order, a new key
// goes ahead of equal keys, and remove drops the first match. Each item
// returns one response with status, bucket and the bucket's fill after the
// operation. One item is handled at a time: the block latches it, reads
// each stored key of its bucket in turn through the single read port of
// the key RAM, whose read data is registered, closes the scan, and then
// writes back the tail entry and the fill count, waiting there while the
// previous response still sits unread in the output register.
// Inserts and removes shift the entries in the same pass, writing each entry
// behind the read pointer. Fill counts live in flip-flops cleared by reset,
// so the block takes items right after reset. A new command is taken while
// the previous response still waits in the output register.
module sorted_bucket_hash_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbht_cmd_if.sink   cmd_i,
  sbht_rsp_if.source rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [sbht_pkg::CMD_W-1:0]        cmd_q;
  logic [sbht_pkg::KEY_W-1:0]        key_q;
  logic [sbht_pkg::BUCKET_W-1:0]     bkt_q;
  logic [sbht_pkg::FILL_W-1:0]       fill_q;
  logic [sbht_pkg::FILL_W-1:0]       rd_idx_q;
  logic                              rd_vld_q;
  logic [sbht_pkg::SLOT_W-1:0]       proc_idx_q;
  logic                              seen_q;
  logic                              match_q;
  logic [sbht_pkg::KEY_W-1:0]        carry_q;
  logic [sbht_pkg::FILL_W-1:0]       fill_cnt_q [sbht_pkg::BUCKETS];

  logic                              out_vld_q;
  logic [sbht_pkg::STATUS_W-1:0]     out_status_q;
  logic [sbht_pkg::BUCKET_W-1:0]     out_bkt_q;
  logic [sbht_pkg::FILL_W-1:0]       out_fill_q;

  logic                              accept;
  logic [sbht_pkg::BUCKET_W-1:0]     in_bkt;
  logic                              is_ins, is_rem, is_full, do_ins;
  logic                              issue, first_ge, load;
  logic                              mem_we;
  logic [sbht_pkg::ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [sbht_pkg::KEY_W-1:0]        mem_wdata, mem_rdata;
  logic [sbht_pkg::STATUS_W-1:0]     res_status;
  logic [sbht_pkg::FILL_W-1:0]       res_fill;

  // Handshake and decode
  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign in_bkt      = cmd_i.key[sbht_pkg::BUCKET_W-1:0];

  assign is_ins  = (cmd_q == sbht_pkg::CMD_INSERT);
  assign is_rem  = (cmd_q == sbht_pkg::CMD_REMOVE);
  assign is_full = (fill_q == sbht_pkg::FILL_MAX);
  assign do_ins  = is_ins && !is_full;

  // Scan: one read per stored entry, compare on the returning data
  assign issue     = (state_q == S_SCAN) && (rd_idx_q != fill_q);
  assign mem_raddr = {bkt_q, rd_idx_q[sbht_pkg::SLOT_W-1:0]};
  assign first_ge  = rd_vld_q && !seen_q && (mem_rdata >= key_q);
  assign load      = (state_q == S_DONE) && (!out_vld_q || rsp_o.ready);

  // Result of the finished item
  always_comb begin
    res_status = sbht_pkg::ST_NOTFOUND;
    res_fill   = fill_q;
    if (is_ins) begin
      if (is_full) begin
        res_status = sbht_pkg::ST_FULL;
      end else begin
        res_status = sbht_pkg::ST_OK;
        res_fill   = fill_q + 1'b1;
      end
    end else if (match_q) begin
      res_status = sbht_pkg::ST_OK;
      if (is_rem) begin
        res_fill = fill_q - 1'b1;
      end
    end
  end

  // Write-back: shift during the scan, tail entry at the end of an insert
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {bkt_q, proc_idx_q};
    mem_wdata = key_q;
    if ((state_q == S_SCAN) && rd_vld_q) begin
      if (do_ins) begin
        if (first_ge) begin
          mem_we = 1'b1;
        end else if (seen_q) begin
          mem_we    = 1'b1;
          mem_wdata = carry_q;
        end
      end else if (is_rem && match_q) begin
        mem_we    = 1'b1;
        mem_waddr = {bkt_q, proc_idx_q - 1'b1};
        mem_wdata = mem_rdata;
      end
    end else if (load && do_ins) begin
      mem_we    = 1'b1;
      mem_waddr = {bkt_q, fill_q[sbht_pkg::SLOT_W-1:0]};
      mem_wdata = seen_q ? carry_q : key_q;
    end
  end

  sbht_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (!issue && !rd_vld_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int b = 0; b < sbht_pkg::BUCKETS; b++) begin
        fill_cnt_q[b] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (load) begin
        fill_cnt_q[bkt_q] <= res_fill;
        out_vld_q         <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Item and scan payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i.command;
      key_q    <= cmd_i.key;
      bkt_q    <= in_bkt;
      fill_q   <= fill_cnt_q[in_bkt];
      rd_idx_q <= '0;
      seen_q   <= 1'b0;
      match_q  <= 1'b0;
    end else begin
      if (issue) begin
        rd_idx_q   <= rd_idx_q + 1'b1;
        proc_idx_q <= rd_idx_q[sbht_pkg::SLOT_W-1:0];
      end
      if (rd_vld_q) begin
        carry_q <= mem_rdata;
      end
      if (first_ge) begin
        seen_q  <= 1'b1;
        match_q <= (mem_rdata == key_q);
      end
    end
    if (load) begin
      out_status_q <= res_status;
      out_bkt_q    <= bkt_q;
      out_fill_q   <= res_fill;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.bucket      = out_bkt_q;
  assign rsp_o.bucket_fill = out_fill_q;

  // A shift write never lands on the entry being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && issue |-> mem_waddr != mem_raddr)
    else $error("key RAM write and read hit the same entry");

  // The read pointer never runs past the bucket's fill
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> rd_idx_q <= fill_q)
    else $error("scan read pointer beyond fill");

  // A refused insert only happens on a full bucket
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_status_q == sbht_pkg::ST_FULL |-> out_fill_q == sbht_pkg::FILL_MAX)
    else $error("full status on a bucket that is not full");

  // The write-back and response load happen together, then the block idles
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> state_q == S_IDLE && out_vld_q)
    else $error("response load did not return to idle");

endmodule
